// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/brrs_pkg.sv =====
package brrs_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned SECS_W           = 8;
    localparam int unsigned TIMER_W          = 18;
    localparam int unsigned CMD_DEPTH        = 2;
    localparam int unsigned CMD_PTR_W        = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W        = $clog2(CMD_DEPTH + 1);
    localparam int unsigned RES_DEPTH        = 2;
    localparam int unsigned RES_PTR_W        = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W        = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RING = 2'd1,
        PH_REST = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [SECS_W-1:0] ring;
        logic [SECS_W-1:0] rest;
        logic [7:0]        count;
    } cmd_t;

    typedef struct packed {
        logic       bell_on;
        phase_t     phase;
        logic [7:0] rings_left;
        logic       done;
    } res_t;

    function automatic logic [TIMER_W-1:0] secs_to_ticks(input logic [SECS_W-1:0] secs);
        logic [TIMER_W+SECS_W-1:0] prod;
        begin
            prod = (TIMER_W+SECS_W)'(secs) * (TIMER_W+SECS_W)'(TICKS_PER_SECOND);
            return prod[TIMER_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/brrs_front.sv =====
module brrs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          action,
    input  logic [7:0]          ring_seconds,
    input  logic [7:0]          rest_seconds,
    input  logic [7:0]          ring_count,
    output logic                cmd_valid,
    output brrs_pkg::cmd_t      cmd,
    input  logic                cmd_pop
);
    import brrs_pkg::*;

    cmd_t                 store [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    cmd_t                 decoded;
    logic                 do_push;
    logic                 do_pop;

    // classify the request
    always_comb
    begin
        decoded.ring  = ring_seconds;
        decoded.rest  = rest_seconds;
        decoded.count = ring_count;
        unique case (action)
            ACT_TICK:  decoded.kind = CMD_TICK;
            ACT_START: decoded.kind = CMD_START;
            ACT_STOP:  decoded.kind = CMD_STOP;
            default:   decoded.kind = CMD_NOP;
        endcase
    end

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/brrs_back.sv =====
module brrs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  brrs_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic                bell_on,
    output logic [1:0]          phase,
    output logic [7:0]          rings_left,
    output logic                sequence_done
);
    import brrs_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [7:0]          rings_reg, rings_next;
    logic                cont_reg, cont_next;
    logic [SECS_W-1:0]   ring_len_reg, ring_len_next;
    logic [SECS_W-1:0]   rest_len_reg, rest_len_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SECS_W-1:0]   pend_ring_reg, pend_ring_next;
    logic [SECS_W-1:0]   pend_rest_reg, pend_rest_next;
    logic [7:0]          pend_count_reg, pend_count_next;
    logic                done;
    res_t                result;

    res_t                 res_store [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 do_pop;
    res_t                 head;

    assign cmd_pop = cmd_valid && (count_reg != RES_CNT_W'(RES_DEPTH));

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        rings_next      = rings_reg;
        cont_next       = cont_reg;
        ring_len_next   = ring_len_reg;
        rest_len_next   = rest_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_ring_next  = pend_ring_reg;
        pend_rest_next  = pend_rest_reg;
        pend_count_next = pend_count_reg;
        done            = 1'b0;

        unique case (cmd.kind)
            CMD_START:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    pend_valid_next = 1'b1;
                    pend_ring_next  = cmd.ring;
                    pend_rest_next  = cmd.rest;
                    pend_count_next = cmd.count;
                end
                else
                begin
                    ring_len_next = cmd.ring;
                    rest_len_next = cmd.rest;
                    cont_next     = (cmd.count == '0);
                    rings_next    = cmd.count;
                    phase_next    = PH_RING;
                    timer_next    = secs_to_ticks(cmd.ring);
                end
            end
            CMD_STOP:
            begin
                phase_next      = PH_IDLE;
                timer_next      = '0;
                rings_next      = '0;
                cont_next       = 1'b0;
                pend_valid_next = 1'b0;
            end
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE && timer_reg > TIMER_W'(1))
                begin
                    timer_next = timer_reg - 1'b1;
                end
                else if (phase_reg == PH_RING)
                begin
                    if (!cont_reg && rings_reg != '0)
                    begin
                        rings_next = rings_reg - 1'b1;
                    end
                    if (cont_reg || rings_next != '0)
                    begin
                        phase_next = PH_REST;
                        timer_next = secs_to_ticks(rest_len_reg);
                    end
                    else
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        if (pend_valid_reg)
                        begin
                            pend_valid_next = 1'b0;
                            ring_len_next   = pend_ring_reg;
                            rest_len_next   = pend_rest_reg;
                            cont_next       = (pend_count_reg == '0);
                            rings_next      = pend_count_reg;
                            phase_next      = PH_RING;
                            timer_next      = secs_to_ticks(pend_ring_reg);
                        end
                    end
                end
                else if (phase_reg == PH_REST)
                begin
                    if (pend_valid_reg)
                    begin
                        pend_valid_next = 1'b0;
                        ring_len_next   = pend_ring_reg;
                        rest_len_next   = pend_rest_reg;
                        cont_next       = (pend_count_reg == '0);
                        rings_next      = pend_count_reg;
                        phase_next      = PH_RING;
                        timer_next      = secs_to_ticks(pend_ring_reg);
                    end
                    else
                    begin
                        phase_next = PH_RING;
                        timer_next = secs_to_ticks(ring_len_reg);
                    end
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        result.bell_on    = (phase_next == PH_RING);
        result.phase      = phase_next;
        result.rings_left = (phase_next != PH_IDLE && !cont_next) ? rings_next : '0;
        result.done       = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            rings_reg      <= '0;
            cont_reg       <= 1'b0;
            ring_len_reg   <= '0;
            rest_len_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_ring_reg  <= '0;
            pend_rest_reg  <= '0;
            pend_count_reg <= '0;
        end
        else if (cmd_pop)
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            rings_reg      <= rings_next;
            cont_reg       <= cont_next;
            ring_len_reg   <= ring_len_next;
            rest_len_reg   <= rest_len_next;
            pend_valid_reg <= pend_valid_next;
            pend_ring_reg  <= pend_ring_next;
            pend_rest_reg  <= pend_rest_next;
            pend_count_reg <= pend_count_next;
        end
    end

    // result queue
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = res_store[rd_ptr_reg];

    assign bell_on       = head.bell_on;
    assign phase         = head.phase;
    assign rings_left    = head.rings_left;
    assign sequence_done = head.done;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd_pop)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + RES_CNT_W'(cmd_pop) - RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_store[wr_ptr_reg] <= result;
        end
    end

endmodule

// ===== rtl/bell_ring_rest_repeat_sequencer.sv =====
// Bell ring/rest sequencer. Every request (tick, start, stop or unused action code)
// gives exactly one result. One request per clock cycle is taken and one result per
// cycle is delivered, unless full or a low pop holds them. A request is registered in the
// command queue, then its result in the result queue. A two-entry command queue sits
// between the decoder and the sequencer, and a two-entry result queue drives the
// outputs, so full rises only when both queues are backed up by pop.
module bell_ring_rest_repeat_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [7:0] ring_seconds,
    input  logic [7:0] rest_seconds,
    input  logic [7:0] ring_count,
    output logic       empty,
    input  logic       pop,
    output logic       bell_on,
    output logic [1:0] phase,
    output logic [7:0] rings_left,
    output logic       sequence_done
);
    import brrs_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    brrs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .ring_seconds (ring_seconds),
        .rest_seconds (rest_seconds),
        .ring_count   (ring_count),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    brrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .bell_on       (bell_on),
        .phase         (phase),
        .rings_left    (rings_left),
        .sequence_done (sequence_done)
    );

endmodule

// ===== rtl/brrs_checker.sv =====
`include "assert_macros.svh"

module brrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       bell_on,
    input logic [1:0] phase,
    input logic [7:0] rings_left,
    input logic       sequence_done
);
    import brrs_pkg::*;

    `ASSERT_SAME(a_bell_matches_phase, !empty, bell_on == (phase == PH_RING))
    `ASSERT_SAME(a_done_only_when_idle_or_restart, !empty && sequence_done,
        phase == PH_IDLE || phase == PH_RING)
    `ASSERT_SAME(a_idle_has_no_count, !empty && phase == PH_IDLE, rings_left == 8'd0)
    `ASSERT_NEXT(a_result_held, !empty && !pop,
        !empty && $stable(bell_on) && $stable(phase) && $stable(rings_left)
        && $stable(sequence_done))

endmodule

bind bell_ring_rest_repeat_sequencer brrs_checker u_brrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .bell_on       (bell_on),
    .phase         (phase),
    .rings_left    (rings_left),
    .sequence_done (sequence_done)
);

// ===== verif/tb_bell_ring_rest_repeat_sequencer.sv =====
`timescale 1ns / 100ps

module tb_bell_ring_rest_repeat_sequencer;

    import brrs_pkg::*;

    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RAND_PASS   = 40;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] ring;
        logic [7:0] rest;
        logic [7:0] cnt;
    } bell_req_t;

    typedef struct packed {
        bell_req_t req;
        logic      typed;
        res_t      want;
    } bell_row_t;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic [1:0] action        = ACT_TICK;
    logic [7:0] ring_seconds  = 8'd0;
    logic [7:0] rest_seconds  = 8'd0;
    logic [7:0] ring_count    = 8'd0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic       bell_on;
    logic [1:0] phase;
    logic [7:0] rings_left;
    logic       sequence_done;

    // typed expectation riding along with the request on the wire
    logic       req_typed     = 1'b0;
    res_t       req_want      = '0;

    res_t        status_q [$];
    bell_row_t   dir_rows [$];
    int unsigned errors       = 0;
    int unsigned stall_cycles = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    bit          hold_req     = 1'b0;

    // predictor state
    phase_t             m_phase;
    logic [TIMER_W-1:0] m_timer;
    logic [7:0]         m_rings;
    logic               m_cont;
    logic [7:0]         m_ring_len;
    logic [7:0]         m_rest_len;
    logic               held_ok;
    logic [7:0]         held_ring;
    logic [7:0]         held_rest;
    logic [7:0]         held_cnt;

    res_t model_res;
    res_t want;

    bell_ring_rest_repeat_sequencer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .ring_seconds  (ring_seconds),
        .rest_seconds  (rest_seconds),
        .ring_count    (ring_count),
        .empty         (empty),
        .pop           (pop),
        .bell_on       (bell_on),
        .phase         (phase),
        .rings_left    (rings_left),
        .sequence_done (sequence_done)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [TIMER_W-1:0] to_ticks(input logic [7:0] secs);
        return TIMER_W'(secs * TICKS_PER_SECOND);
    endfunction

    function automatic void launch_sequence(input logic [7:0] rs, input logic [7:0] rt,
                                            input logic [7:0] rc);
        m_ring_len = rs;
        m_rest_len = rt;
        m_cont     = (rc == 8'd0);
        m_rings    = rc;
        m_phase    = PH_RING;
        m_timer    = to_ticks(rs);
    endfunction

    function automatic void take_held();
        held_ok = 1'b0;
        launch_sequence(held_ring, held_rest, held_cnt);
    endfunction

    function automatic void step_bell(input bell_req_t r, output res_t s);
        logic done;
        done = 1'b0;
        if (r.act == ACT_START)
        begin
            if (m_phase != PH_IDLE)
            begin
                held_ok   = 1'b1;
                held_ring = r.ring;
                held_rest = r.rest;
                held_cnt  = r.cnt;
            end
            else
                launch_sequence(r.ring, r.rest, r.cnt);
        end
        else if (r.act == ACT_STOP)
        begin
            m_phase = PH_IDLE;
            m_timer = '0;
            m_rings = '0;
            m_cont  = 1'b0;
            held_ok = 1'b0;
        end
        else if (r.act == ACT_TICK)
        begin
            if (m_phase == PH_RING)
            begin
                if (m_timer > 1)
                    m_timer = m_timer - 1'b1;
                else
                begin
                    if (!m_cont && m_rings != 8'd0)
                        m_rings = m_rings - 1'b1;
                    if (m_cont || m_rings != 8'd0)
                    begin
                        m_phase = PH_REST;
                        m_timer = to_ticks(m_rest_len);
                    end
                    else
                    begin
                        m_phase = PH_IDLE;
                        m_timer = '0;
                        done    = 1'b1;
                        if (held_ok)
                            take_held();
                    end
                end
            end
            else if (m_phase == PH_REST)
            begin
                if (m_timer > 1)
                    m_timer = m_timer - 1'b1;
                else if (held_ok)
                    take_held();
                else
                begin
                    m_phase = PH_RING;
                    m_timer = to_ticks(m_ring_len);
                end
            end
        end
        s.bell_on    = (m_phase == PH_RING);
        s.phase      = m_phase;
        s.rings_left = (m_phase != PH_IDLE && !m_cont) ? m_rings : 8'd0;
        s.done       = done;
    endfunction

    function automatic logic [7:0] pick_secs();
        int unsigned dice;
        dice = $urandom_range(0, 99);
        if (dice < 75)
            return 8'd0;
        if (dice < 87)
            return 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        $display("%0t ns: %s got %0d expected %0d", $time, what, got, exp_val);
    endtask

    task automatic add_row(input logic [1:0] act, input logic [7:0] rs, input logic [7:0] rt,
                           input logic [7:0] rc, input logic typed, input logic bell,
                           input phase_t ph, input logic [7:0] left, input logic done);
        bell_row_t row;
        row.req  = '{act, rs, rt, rc};
        row.typed = typed;
        row.want  = '{bell, ph, left, done};
        dir_rows.push_back(row);
    endtask

    // called and returns at a falling edge
    task automatic send_req(input bell_req_t r, input logic typed, input res_t exp_res);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        action       <= r.act;
        ring_seconds <= r.ring;
        rest_seconds <= r.rest;
        ring_count   <= r.cnt;
        req_typed    <= typed;
        req_want     <= exp_res;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (status_q.size() == 0)
                    report_mismatch("result with no request outstanding", 1, 0);
                else
                begin
                    want = status_q.pop_front();
                    if (bell_on !== want.bell_on)
                        report_mismatch("bell_on", bell_on, want.bell_on);
                    if (phase !== want.phase)
                        report_mismatch("phase", phase, want.phase);
                    if (rings_left !== want.rings_left)
                        report_mismatch("rings_left", rings_left, want.rings_left);
                    if (sequence_done !== want.done)
                        report_mismatch("sequence_done", sequence_done, want.done);
                end
            end
            if (push && !full)
            begin
                step_bell('{action, ring_seconds, rest_seconds, ring_count}, model_res);
                status_q.push_back(req_typed ? req_want : model_res);
            end
            if ((pop && !empty) || (push && !full))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        bell_req_t   r;
        int unsigned dice;
        int unsigned sent;

        m_phase    = PH_IDLE;
        m_timer    = '0;
        m_rings    = '0;
        m_cont     = 1'b0;
        m_ring_len = '0;
        m_rest_len = '0;
        held_ok    = 1'b0;
        held_ring  = '0;
        held_rest  = '0;
        held_cnt   = '0;

        //       action      ring    rest    count  typ bell phase    left  done
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_STOP,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_UNUSED, 8'd255, 8'd255, 8'd255, 1, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_START,  8'd0,   8'd0,   8'd1,   1, 1, PH_RING, 8'd1,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   1);
        // continuous ringing, then a start held over a ring and a rest
        add_row(ACT_START,  8'd0,   8'd0,   8'd0,   1, 1, PH_RING, 8'd0,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_REST, 8'd0,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 1, PH_RING, 8'd0,   0);
        add_row(ACT_START,  8'd255, 8'd255, 8'd255, 1, 1, PH_RING, 8'd0,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_REST, 8'd0,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 1, PH_RING, 8'd255, 0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   0, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_UNUSED, 8'd0,   8'd0,   8'd0,   0, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_STOP,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);
        // stop drops a held start
        add_row(ACT_START,  8'd0,   8'd0,   8'd2,   1, 1, PH_RING, 8'd2,   0);
        add_row(ACT_START,  8'd170, 8'd85,  8'd85,  1, 1, PH_RING, 8'd2,   0);
        add_row(ACT_STOP,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);
        // counted run ends and a held start takes over on the same tick
        add_row(ACT_START,  8'd0,   8'd0,   8'd2,   1, 1, PH_RING, 8'd2,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 0, PH_REST, 8'd1,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 1, PH_RING, 8'd1,   0);
        add_row(ACT_START,  8'd0,   8'd0,   8'd3,   1, 1, PH_RING, 8'd1,   0);
        add_row(ACT_TICK,   8'd0,   8'd0,   8'd0,   1, 1, PH_RING, 8'd3,   1);
        add_row(ACT_STOP,   8'd0,   8'd0,   8'd0,   1, 0, PH_IDLE, 8'd0,   0);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 73;
        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        for (int pass_no = 0; pass_no < 3; pass_no++)
        begin
            tx_idle_pct = (pass_no == 0) ? 10 : (pass_no == 1) ? 73 : 0;
            rx_idle_pct = (pass_no == 0) ? 73 : (pass_no == 1) ? 10 : 0;
            if (pass_no == 0)
                hold_req = 1'b1;
            sent = 0;
            while (sent < RAND_PASS)
            begin
                r.ring = pick_secs();
                r.rest = pick_secs();
                dice   = $urandom_range(0, 99);
                r.cnt  = (dice < 25) ? 8'd0 :
                         (dice < 75) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(0, 255));
                dice   = $urandom_range(0, 99);
                if (m_phase == PH_IDLE)
                    r.act = (dice < 70) ? ACT_START : (dice < 85) ? ACT_TICK :
                            (dice < 97) ? ACT_STOP : ACT_UNUSED;
                // long phase: stop more often so short ones still get exercised
                else if (m_timer > 30)
                    r.act = (dice < 35) ? ACT_STOP : (dice < 45) ? ACT_START :
                            (dice < 98) ? ACT_TICK : ACT_UNUSED;
                else
                    r.act = (dice < 80) ? ACT_TICK : (dice < 90) ? ACT_START :
                            (dice < 97) ? ACT_STOP : ACT_UNUSED;
                send_req(r, 1'b0, '0);
                if (r.act != ACT_UNUSED)
                    sent++;
            end
        end

        // one full-length one-second ring, ending with a held start taking over
        send_req('{ACT_STOP, 8'd0, 8'd0, 8'd0}, 1'b0, '0);
        send_req('{ACT_START, 8'd1, 8'd0, 8'd1}, 1'b0, '0);
        send_req('{ACT_START, 8'd0, 8'd0, 8'd1}, 1'b0, '0);
        repeat (TICKS_PER_SECOND + 1)
            send_req('{ACT_TICK, 8'd0, 8'd0, 8'd0}, 1'b0, '0);

        push <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (errors == 0 && status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
